// ----- sv/hic_pkg.sv -----
// package with constants and decode helpers for the hex id crc7 checker
`default_nettype none

package hic_pkg;

    localparam logic [7:0] CRC_POLY   = 8'h91;
    localparam logic [7:0] CRC_SUBST  = 8'h6B;
    localparam int         ID_CHARS   = 16;
    localparam int         ID_BYTES   = 8;
    localparam int         COUNT_W    = 5;
    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(ID_CHARS);
    localparam logic [COUNT_W-1:0] COUNT_SAT  = COUNT_W'(ID_CHARS + 1);

    // hex flag in bit 4, digit value in bits 3..0
    typedef logic [4:0] hex_code_t;
    typedef logic [6:0] crc_t;

    // ascii letter or digit
    function automatic logic is_alnum(input logic [7:0] c);
        is_alnum = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                   (c >= "a" && c <= "z");
    endfunction

    // hex digit decode, zero when not a hex digit
    function automatic hex_code_t hex_code(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        hex_code = 5'h00;
        if (c >= "0" && c <= "9")
        begin
            d = c - 8'h30;
            hex_code = {1'b1, d[3:0]};
        end
        else if (c >= "A" && c <= "F")
        begin
            d = c - 8'h37;
            hex_code = {1'b1, d[3:0]};
        end
        else if (c >= "a" && c <= "f")
        begin
            d = c - 8'h57;
            hex_code = {1'b1, d[3:0]};
        end
    endfunction

    // reflected crc7 over one byte, eight shift-xor steps
    function automatic crc_t crc_byte(input crc_t crc, input logic [7:0] b);
        logic [7:0] x;
        x = {1'b0, crc} ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (x[0])
                x = x ^ CRC_POLY;
            x = x >> 1;
        end
        crc_byte = x[6:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/hex_id_crc7_checker_core.sv -----
// top level of the hex id crc7 checker
`default_nettype none

// Checks a 16-character alphanumeric ID streamed one character per transaction,
// with last_char marking the end; one id_valid result comes out for each marked
// character and none for the others. The pair decode and the eight-step crc
// update sit between the running state registers and the result register, so
// a new character is taken in every cycle while the result register is free
// or being drained. in_ready drops only while a result waits and out_ready is
// low. time_sign_check (reset 1) is written through cfg_wr_en/cfg_wr_data and
// should change only while the block is idle.
module hex_id_crc7_checker_core
    import hic_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] char_code,
    input  wire logic       last_char,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            id_valid
);

    logic               time_sign_check_reg;
    logic [COUNT_W-1:0] char_count_reg, char_count_next;
    logic               all_alnum_reg, all_alnum_next;
    hex_code_t          first_half_reg, first_half_next;
    crc_t               crc_reg, crc_next;
    logic [7:0]         check_byte_reg, check_byte_next;
    logic [3:0]         version_nibble_reg, version_nibble_next;
    logic               time_sign_reg, time_sign_next;
    logic               out_valid_reg, out_valid_next;
    logic               id_valid_reg, id_valid_next;

    logic               in_fire;
    logic               ok;
    hex_code_t          second;
    logic [7:0]         byte_val;
    logic [2:0]         byte_idx;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign id_valid  = id_valid_reg;

    // pair decode of the current character with the held first half
    always_comb
    begin
        second   = hex_code(char_code);
        byte_idx = char_count_reg[3:1];
        if (!first_half_reg[4])
            byte_val = 8'h00;
        else if (!second[4])
            byte_val = {4'h0, first_half_reg[3:0]};
        else
            byte_val = {first_half_reg[3:0], second[3:0]};
    end

    // running state update for one character
    always_comb
    begin
        char_count_next     = char_count_reg;
        all_alnum_next      = all_alnum_reg && is_alnum(char_code);
        first_half_next     = first_half_reg;
        crc_next            = crc_reg;
        check_byte_next     = check_byte_reg;
        version_nibble_next = version_nibble_reg;
        time_sign_next      = time_sign_reg;

        if (char_count_reg < COUNT_FULL)
        begin
            if (!char_count_reg[0])
            begin
                first_half_next = second;
            end
            else
            begin
                if (byte_idx == 3'd0)
                    version_nibble_next = byte_val[7:4];
                if (byte_idx == 3'd5)
                    time_sign_next = byte_val[7];
                if (byte_idx == 3'd1)
                begin
                    check_byte_next = byte_val;
                    crc_next        = crc_byte(crc_reg, CRC_SUBST);
                end
                else
                begin
                    crc_next = crc_byte(crc_reg, byte_val);
                end
            end
        end
        if (char_count_reg < COUNT_SAT)
            char_count_next = char_count_reg + 1'b1;

        ok = (char_count_next == COUNT_FULL) && all_alnum_next &&
             (version_nibble_next == 4'h0) && ({1'b0, crc_next} == check_byte_next) &&
             !(time_sign_check_reg && time_sign_next);
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        id_valid_next  = id_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (in_fire && last_char)
        begin
            out_valid_next = 1'b1;
            id_valid_next  = ok;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            time_sign_check_reg <= 1'b1;
        else if (cfg_wr_en)
            time_sign_check_reg <= cfg_wr_data;
    end

    // id state, cleared after each marked character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg     <= '0;
            all_alnum_reg      <= 1'b1;
            first_half_reg     <= '0;
            crc_reg            <= '0;
            check_byte_reg     <= '0;
            version_nibble_reg <= '0;
            time_sign_reg      <= 1'b0;
        end
        else if (in_fire)
        begin
            if (last_char)
            begin
                char_count_reg     <= '0;
                all_alnum_reg      <= 1'b1;
                first_half_reg     <= '0;
                crc_reg            <= '0;
                check_byte_reg     <= '0;
                version_nibble_reg <= '0;
                time_sign_reg      <= 1'b0;
            end
            else
            begin
                char_count_reg     <= char_count_next;
                all_alnum_reg      <= all_alnum_next;
                first_half_reg     <= first_half_next;
                crc_reg            <= crc_next;
                check_byte_reg     <= check_byte_next;
                version_nibble_reg <= version_nibble_next;
                time_sign_reg      <= time_sign_next;
            end
        end
    end

    // output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        id_valid_reg <= id_valid_next;
    end

endmodule

`default_nettype wire

// ----- sv/hic_checker.sv -----
// port-level assertions for the hex id crc7 checker and their bind
`default_nettype none

module hic_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       last_char,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       id_valid
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(id_valid))
        else $error("stalled result changed");

    // a marked character always yields a result next cycle
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_char |=> out_valid)
        else $error("marked character gave no result");

    // an unmarked character never invents a result
    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !last_char && !(out_valid && !out_ready) |=> !out_valid)
        else $error("result without a marked character");

    // input stalls only behind a waiting result
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with free result register");

endmodule

bind hex_id_crc7_checker_core hic_checker u_hic_checker (.*);

`default_nettype wire

// ----- tb/hex_id_crc7_checker_core_tb.sv -----
// testbench for the hex id crc7 checker: random id streams checked against a local predictor
`timescale 1ns / 1ps

module hex_id_crc7_checker_core_tb;
    import hic_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_wr_en;
    logic       cfg_wr_data;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] char_code;
    logic       last_char;
    logic       out_valid;
    logic       out_ready;
    logic       id_valid;

    // predictor state
    logic [4:0] seen;
    logic       alnum_ok;
    logic [4:0] pend_hex;
    logic [6:0] crc_acc;
    logic [7:0] rx_check;
    logic [3:0] ver_hi;
    logic       t_sign;
    logic       sign_chk;

    bit         expected_flags[$];
    logic [7:0] id_buf[$];
    bit         want_flag;
    int         err_count = 0;
    int         chars_sent = 0;
    bit         steady_send = 1'b0;
    int         hold_cycles = 0;
    bit         holding = 1'b0;

    hex_id_crc7_checker_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_code  (char_code),
        .last_char  (last_char),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .id_valid   (id_valid)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic bit is_id_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    // bit 4 flags a hex digit, bits 3..0 its value
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return {1'b1, c[3:0]};
        if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
            return {1'b1, c[3:0] + 4'd9};
        return 5'h00;
    endfunction

    // reflected crc7, lsb first
    function automatic logic [6:0] crc7_fold(input logic [6:0] acc, input logic [7:0] b);
        logic [7:0] r;
        r = {1'b0, acc} ^ b;
        repeat (8)
            r = (r >> 1) ^ (r[0] ? (CRC_POLY >> 1) : 8'h00);
        return r[6:0];
    endfunction

    task automatic clear_tracker();
        seen     = '0;
        alnum_ok = 1'b1;
        pend_hex = '0;
        crc_acc  = '0;
        rx_check = '0;
        ver_hi   = '0;
        t_sign   = 1'b0;
    endtask

    // update on one accepted character, queue a flag on the last one
    task automatic track_char(input logic [7:0] c, input bit is_last);
        logic [4:0] code;
        logic [7:0] val;
        int         idx;
        code = hex_nibble(c);
        if (!is_id_char(c))
            alnum_ok = 1'b0;
        if (seen < ID_CHARS)
        begin
            if (!seen[0])
                pend_hex = code;
            else
            begin
                idx = seen >> 1;
                if (!pend_hex[4])
                    val = 8'h00;
                else if (!code[4])
                    val = {4'h0, pend_hex[3:0]};
                else
                    val = {pend_hex[3:0], code[3:0]};
                if (idx == 0)
                    ver_hi = val[7:4];
                if (idx == 5)
                    t_sign = val[7];
                if (idx == 1)
                begin
                    rx_check = val;
                    val = CRC_SUBST;
                end
                crc_acc = crc7_fold(crc_acc, val);
            end
        end
        if (seen < ID_CHARS + 1)
            seen++;
        if (is_last)
        begin
            expected_flags.push_back(seen == ID_CHARS && alnum_ok && ver_hi == 4'h0 &&
                                     {1'b0, crc_acc} == rx_check && !(sign_chk && t_sign));
            clear_tracker();
        end
    endtask

    // ---------------------------------------------------------------
    // id generation
    // ---------------------------------------------------------------

    // mostly short gaps, a few long ones
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + {4'h0, n};
        return ($urandom_range(0, 1) ? "a" : "A") + {4'h0, n} - 8'd10;
    endfunction

    // letter outside a..f
    function automatic logic [7:0] plain_letter();
        return ($urandom_range(0, 1) ? "g" : "G") + 8'($urandom_range(0, 19));
    endfunction

    function automatic logic [7:0] any_alnum();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10)
            return "0" + 8'(r);
        if (r < 36)
            return "A" + 8'(r - 10);
        return "a" + 8'(r - 36);
    endfunction

    // byte as a character pair, sometimes through the short decode forms
    task automatic put_byte(input logic [7:0] v);
        int r;
        r = $urandom_range(0, 9);
        if (v == 8'h00 && r < 3)
        begin
            id_buf.push_back(plain_letter());
            id_buf.push_back(any_alnum());
        end
        else if (v[7:4] == 4'h0 && r < 3)
        begin
            id_buf.push_back(hex_char(v[3:0]));
            id_buf.push_back(plain_letter());
        end
        else
        begin
            id_buf.push_back(hex_char(v[7:4]));
            id_buf.push_back(hex_char(v[3:0]));
        end
    endtask

    // well-formed id with a matching crc byte
    task automatic make_good_id(input bit neg_time);
        logic [7:0] bytes[8];
        logic [6:0] crc;
        id_buf.delete();
        for (int k = 0; k < ID_BYTES; k++)
            bytes[k] = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 15))
                                                    : 8'($urandom_range(0, 255));
        bytes[0][7:4] = 4'h0;
        bytes[5][7] = neg_time;
        crc = '0;
        for (int k = 0; k < ID_BYTES; k++)
            crc = crc7_fold(crc, (k == 1) ? CRC_SUBST : bytes[k]);
        bytes[1] = {1'b0, crc};
        for (int k = 0; k < ID_BYTES; k++)
            put_byte(bytes[k]);
    endtask

    // damage a well-formed id in one way
    task automatic break_id();
        int         pos;
        int         n;
        logic [7:0] c;
        pos = $urandom_range(0, ID_CHARS - 1);
        case ($urandom_range(0, 5))
            0:
            begin
                if ($urandom_range(0, 1))
                    id_buf.delete(pos);
                else
                begin
                    n = $urandom_range(1, ID_CHARS - 1);
                    while (id_buf.size() > n)
                        void'(id_buf.pop_back());
                end
            end
            1:
                repeat ($urandom_range(1, 4))
                    id_buf.push_back(any_alnum());
            2:
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (is_id_char(c));
                id_buf[pos] = c;
            end
            3:
            begin
                // crc byte that a 7-bit crc can never match
                c = 8'($urandom_range(128, 255));
                id_buf[2] = hex_char(c[7:4]);
                id_buf[3] = hex_char(c[3:0]);
            end
            4:
                id_buf[0] = hex_char(4'($urandom_range(1, 15)));
            default:
                id_buf[pos] = any_alnum();
        endcase
    endtask

    task automatic make_noise();
        id_buf.delete();
        repeat ($urandom_range(1, 24))
            id_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    // ---------------------------------------------------------------
    // driving
    // ---------------------------------------------------------------

    // offer one character and hold it until the transaction completes
    task automatic send_char(input logic [7:0] c, input bit is_last);
        int gap;
        gap = pick_gap(steady_send);
        if (gap > 0)
        begin
            if (in_valid)
                in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        last_char <= is_last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        track_char(c, is_last);
        chars_sent++;
    endtask

    task automatic send_id();
        for (int k = 0; k < id_buf.size(); k++)
            send_char(id_buf[k], k == id_buf.size() - 1);
    endtask

    task automatic wait_results_done();
        if (in_valid)
            in_valid <= 1'b0;
        while (expected_flags.size() != 0)
            @(posedge clk);
    endtask

    // register write with the block idle
    task automatic set_sign_check(input bit v);
        wait_results_done();
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sign_chk = v;
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // valid id, nul, top code and a lone letter
    task automatic test_directed_cases();
        make_good_id(1'b0);
        send_id();
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        send_char("z", 1'b1);
    endtask

    // receiver holds off while ids keep coming, then everything drains
    task automatic test_output_stall();
        hold_cycles = 80;
        while (!holding)
            @(posedge clk);
        steady_send = 1'b1;
        repeat (8)
            send_char(any_alnum(), 1'b1);
        make_good_id(1'b0);
        send_id();
        steady_send = 1'b0;
        wait_results_done();
    endtask

    // mixed well-formed, damaged and noise ids under one register setting
    task automatic test_random_stream(input bit sign_on, input int n_chars);
        int stop_at;
        int r;
        set_sign_check(sign_on);
        stop_at = chars_sent + n_chars;
        while (chars_sent < stop_at)
        begin
            steady_send = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 99);
            if (r < 55)
                make_good_id($urandom_range(0, 2) == 0);
            else if (r < 85)
            begin
                make_good_id($urandom_range(0, 2) == 0);
                break_id();
            end
            else
                make_noise();
            send_id();
        end
        steady_send = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_flags.size() == 0)
            begin
                $display("%0t: unexpected transaction, actual id_valid %0b", $time, id_valid);
                err_count++;
            end
            else
            begin
                want_flag = expected_flags.pop_front();
                if (id_valid !== want_flag)
                begin
                    $display("%0t: id_valid mismatch, expected %0b, actual %0b",
                             $time, want_flag, id_valid);
                    err_count++;
                end
            end
        end
    end

    // receiver: random stalls, long ready stretches, one requested hold-off
    initial
    begin
        int stall;
        int run;
        out_ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                stall = hold_cycles;
                hold_cycles = 0;
                holding = 1'b1;
            end
            else
                stall = pick_gap(1'b0);
            if (stall > 0)
            begin
                if (out_ready)
                    out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                holding = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!out_ready)
                out_ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
            repeat (run) @(posedge clk);
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial
    begin
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
        in_valid    <= 1'b0;
        char_code   <= 8'h00;
        last_char   <= 1'b0;
        sign_chk = 1'b1;
        clear_tracker();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed_cases();
        test_output_stall();
        test_random_stream(1'b0, 600);
        test_random_stream(1'b1, 600);
        test_random_stream(1'b0, 600);

        wait_results_done();
        repeat (10) @(posedge clk);
        if (err_count == 0 && expected_flags.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ----- hex_id_crc7_checker_core.f -----
sv/hic_pkg.sv
sv/hex_id_crc7_checker_core.sv
sv/hic_checker.sv
tb/hex_id_crc7_checker_core_tb.sv
